// ===== src/masked_pyramid_gradient_defines.svh =====
// ----------------------------------------------------------------------------
// masked pyramid gradient assertion macros
// concurrent checks, compiled out when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef MASKED_PYRAMID_GRADIENT_DEFINES_SVH
`define MASKED_PYRAMID_GRADIENT_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define PMG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define PMG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define PMG_ASSERT(lbl, clk, rst_n, prop, msg)
`define PMG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/pmg_pkg.sv =====
// ----------------------------------------------------------------------------
// pmg_pkg
// shared types and constants of the masked pyramid gradient block
// ----------------------------------------------------------------------------
package pmg_pkg;

    localparam int PIX_W      = 16;
    localparam int GRAD_W     = 17;
    localparam int SQ_W       = 32;
    localparam int MAG_W      = 33;
    localparam int PSUM_W     = 17;
    localparam int SUM_W      = 18;
    localparam int PCNT_W     = 2;
    localparam int CNT_W      = 3;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_ENABLE  = 2'd2;

    localparam logic [CFG_W-1:0] RST_LEVEL_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0] RST_LEVEL_HEIGHT = 12'd480;
    localparam int MIN_WIDTH  = 4;
    localparam int MIN_HEIGHT = 3;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for x < 2**19
    localparam int DIV3_MUL_W  = 19;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 19'd349526;
    localparam int DIV3_SHIFT  = 20;
    localparam int DIV3_PROD_W = SUM_W + DIV3_MUL_W;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic grad;
        logic down;
        logic last;
    } t_flags;

    typedef struct packed {
        logic right;
        logic left;
        logic above;
    } t_win_ok;

    typedef struct packed {
        logic [PCNT_W-1:0] cnt;
        logic [PSUM_W-1:0] sum;
    } t_pair;

endpackage

// ===== src/pmg_window.sv =====
// ----------------------------------------------------------------------------
// pmg_window
// circular pixel window in block ram, three taps read into registers on each write
// ----------------------------------------------------------------------------
`include "masked_pyramid_gradient_defines.svh"

module pmg_window #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr,
    input  pmg_pkg::t_pix                        i_pixel,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     i_k_right,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     i_k_left,
    input  logic [$clog2(2*MAX_WIDTH+1)-1:0]     i_k_above,
    output pmg_pkg::t_pix                        o_right,
    output pmg_pkg::t_pix                        o_left,
    output pmg_pkg::t_pix                        o_above,
    output pmg_pkg::t_win_ok                     o_ok
);
    import pmg_pkg::*;

    localparam int DEPTH = 2 * MAX_WIDTH + 1;
    localparam int KW    = $clog2(DEPTH);
    localparam int FW    = $clog2(DEPTH + 1);

    t_pix mem_lr [DEPTH];
    t_pix mem_up [DEPTH];

    logic [KW-1:0] r_wp;
    logic [KW-1:0] n_wp;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [KW-1:0] a_right;
    logic [KW-1:0] a_left;
    logic [KW-1:0] a_above;
    t_pix          r_q_right;
    t_pix          r_q_left;
    t_pix          r_q_above;
    t_win_ok       r_ok;

    function automatic logic [KW-1:0] back_addr(input logic [KW-1:0] p,
                                                input logic [KW-1:0] k);
        logic [KW:0] wrap;
        wrap = {1'b0, p} + (KW+1)'(DEPTH) - {1'b0, k};
        return (p >= k) ? (p - k) : wrap[KW-1:0];
    endfunction

    assign n_wp    = (r_wp == KW'(DEPTH - 1)) ? '0 : r_wp + KW'(1);
    assign n_fill  = (r_fill == FW'(DEPTH)) ? r_fill : r_fill + FW'(1);
    assign a_right = back_addr(n_wp, i_k_right);
    assign a_left  = back_addr(n_wp, i_k_left);
    assign a_above = back_addr(n_wp, i_k_above);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (i_wr) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem_lr[n_wp] <= i_pixel;
            mem_up[n_wp] <= i_pixel;
            r_q_right    <= mem_lr[a_right];
            r_q_left     <= mem_lr[a_left];
            r_q_above    <= mem_up[a_above];
            // entries not yet written since reset have their ok flag cleared
            r_ok.right   <= FW'(i_k_right) < n_fill;
            r_ok.left    <= FW'(i_k_left)  < n_fill;
            r_ok.above   <= FW'(i_k_above) < n_fill;
        end
    end

    assign o_right = r_q_right;
    assign o_left  = r_q_left;
    assign o_above = r_q_above;
    assign o_ok    = r_ok;

    `PMG_ASSERT(a_fill_grows, i_clk, i_rst_n, r_fill >= $past(r_fill), "window fill shrank")

endmodule

// ===== src/pmg_pair.sv =====
// ----------------------------------------------------------------------------
// pmg_pair
// per column pair sum and valid count of the even row, block ram
// ----------------------------------------------------------------------------
module pmg_pair #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr,
    input  logic                                 i_rd,
    input  logic [$clog2(MAX_WIDTH/2)-1:0]       i_idx,
    input  pmg_pkg::t_pair                       i_data,
    output pmg_pkg::t_pair                       o_q
);
    import pmg_pkg::*;

    localparam int DEPTH = MAX_WIDTH / 2;

    t_pair mem [DEPTH];
    t_pair r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_idx] <= i_data;
        end
        if (i_rd) begin
            r_q <= mem[i_idx];
        end
    end

    assign o_q = r_q;

endmodule

// ===== src/pmg_arith.sv =====
// ----------------------------------------------------------------------------
// pmg_arith
// difference, square and masked mean stages with output register
// ----------------------------------------------------------------------------
`include "masked_pyramid_gradient_defines.svh"

module pmg_arith (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_acc,
    input  pmg_pkg::t_pix                        i_below,
    input  logic [pmg_pkg::PSUM_W-1:0]           i_psum,
    input  logic [pmg_pkg::PCNT_W-1:0]           i_pcnt,
    input  pmg_pkg::t_flags                      i_flags,
    input  pmg_pkg::t_pix                        i_right,
    input  pmg_pkg::t_pix                        i_left,
    input  pmg_pkg::t_pix                        i_above,
    input  pmg_pkg::t_win_ok                     i_ok,
    input  pmg_pkg::t_pair                       i_pair,
    input  logic                                 i_stall,
    output logic                                 o_s1_free,
    output logic                                 o_valid,
    output logic signed [pmg_pkg::GRAD_W-1:0]    o_grad_x,
    output logic signed [pmg_pkg::GRAD_W-1:0]    o_grad_y,
    output logic [pmg_pkg::MAG_W-1:0]            o_grad_mag_sq,
    output logic                                 o_grad_valid,
    output pmg_pkg::t_pix                        o_down_pixel,
    output logic                                 o_down_valid,
    output logic                                 o_frame_last
);
    import pmg_pkg::*;

    logic adv_out, adv3, adv2, adv1;

    // stage 1: capture beside the ram read data
    logic                r_v1;
    t_flags              r_f1;
    t_pix                r_below1;
    logic [PSUM_W-1:0]   r_psum1;
    logic [PCNT_W-1:0]   r_pcnt1;

    t_pix                rv, lv, av;
    logic signed [GRAD_W-1:0] gx1, gy1;
    logic [SUM_W-1:0]    dsum1;
    logic [CNT_W-1:0]    dcnt1;

    // stage 2
    logic                r_v2;
    t_flags              r_f2;
    logic signed [GRAD_W-1:0] r_gx2, r_gy2;
    logic [SUM_W-1:0]    r_dsum2;
    logic [CNT_W-1:0]    r_dcnt2;

    logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
    logic [DIV3_PROD_W-1:0]     prod3;

    // stage 3
    logic                r_v3;
    t_flags              r_f3;
    logic signed [GRAD_W-1:0] r_gx3, r_gy3;
    logic [SQ_W-1:0]     r_sqx3, r_sqy3;
    logic [SUM_W-1:0]    r_dsum3;
    logic [CNT_W-1:0]    r_dcnt3;
    t_pix                r_q3;

    logic [MAG_W-1:0]    mag3;
    t_pix                dpix3;

    // output register
    logic                r_vo;
    logic signed [GRAD_W-1:0] r_gx_o, r_gy_o;
    logic [MAG_W-1:0]    r_mag_o;
    logic                r_gv_o, r_dv_o, r_last_o;
    t_pix                r_dpix_o;

    assign adv_out   = !r_vo || !i_stall;
    assign adv3      = !r_v3 || adv_out;
    assign adv2      = !r_v2 || adv3;
    assign adv1      = !r_v1 || adv2;
    assign o_s1_free = adv1;

    always_comb begin
        rv    = i_ok.right ? i_right : '0;
        lv    = i_ok.left  ? i_left  : '0;
        av    = i_ok.above ? i_above : '0;
        gx1   = '0;
        gy1   = '0;
        if (r_f1.grad && rv != '0 && lv != '0) begin
            gx1 = $signed({1'b0, rv}) - $signed({1'b0, lv});
        end
        if (r_f1.grad && r_below1 != '0 && av != '0) begin
            gy1 = $signed({1'b0, r_below1}) - $signed({1'b0, av});
        end
        dsum1 = {1'b0, r_psum1} + {1'b0, i_pair.sum};
        dcnt1 = {1'b0, r_pcnt1} + {1'b0, i_pair.cnt};
    end

    assign sqx_full = r_gx2 * r_gx2;
    assign sqy_full = r_gy2 * r_gy2;
    assign prod3    = DIV3_PROD_W'(r_dsum2) * DIV3_PROD_W'(DIV3_MUL);

    always_comb begin
        mag3 = {1'b0, r_sqx3} + {1'b0, r_sqy3};
        unique case (r_dcnt3)
            3'd1:    dpix3 = PIX_W'(r_dsum3);
            3'd2:    dpix3 = PIX_W'(r_dsum3 >> 1);
            3'd3:    dpix3 = r_q3;
            3'd4:    dpix3 = PIX_W'(r_dsum3 >> 2);
            default: dpix3 = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_acc;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv_out) begin
                r_vo <= r_v3 && (r_f3.grad || r_f3.down);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_acc) begin
            r_f1     <= i_flags;
            r_below1 <= i_below;
            r_psum1  <= i_psum;
            r_pcnt1  <= i_pcnt;
        end
        if (adv2 && r_v1) begin
            r_f2    <= r_f1;
            r_gx2   <= gx1;
            r_gy2   <= gy1;
            r_dsum2 <= dsum1;
            r_dcnt2 <= dcnt1;
        end
        if (adv3 && r_v2) begin
            r_f3    <= r_f2;
            r_gx3   <= r_gx2;
            r_gy3   <= r_gy2;
            r_sqx3  <= SQ_W'($unsigned(sqx_full));
            r_sqy3  <= SQ_W'($unsigned(sqy_full));
            r_dsum3 <= r_dsum2;
            r_dcnt3 <= r_dcnt2;
            r_q3    <= PIX_W'(prod3 >> DIV3_SHIFT);
        end
        if (adv_out && r_v3) begin
            r_gx_o   <= r_gx3;
            r_gy_o   <= r_gy3;
            r_mag_o  <= mag3;
            r_gv_o   <= r_f3.grad;
            r_dv_o   <= r_f3.down;
            r_dpix_o <= r_f3.down ? dpix3 : '0;
            r_last_o <= r_f3.last;
        end
    end

    assign o_valid       = r_vo;
    assign o_grad_x      = r_gx_o;
    assign o_grad_y      = r_gy_o;
    assign o_grad_mag_sq = r_mag_o;
    assign o_grad_valid  = r_gv_o;
    assign o_down_pixel  = r_dpix_o;
    assign o_down_valid  = r_dv_o;
    assign o_frame_last  = r_last_o;

    `PMG_ASSERT(a_has_result, i_clk, i_rst_n, o_valid |-> (o_grad_valid || o_down_valid), "empty result transfer")
    `PMG_ASSERT(a_grad_zero, i_clk, i_rst_n, (o_valid && !o_grad_valid) |-> (o_grad_x == '0 && o_grad_y == '0 && o_grad_mag_sq == '0), "gradient fields set without gradient")
    `PMG_ASSERT(a_down_zero, i_clk, i_rst_n, (o_valid && !o_down_valid) |-> (o_down_pixel == '0), "down pixel set without downsample")

endmodule

// ===== src/masked_pyramid_gradient.sv =====
// ----------------------------------------------------------------------------
// masked_pyramid_gradient: one pixel per cycle unless the input is stalled
// each result passes the ram read, difference and square stages and the output register
// the input stalls only when all four stages hold items and the output is stalled
// synchronous active-low reset loads config defaults, clears counters, pointers and valids
// ----------------------------------------------------------------------------
`include "masked_pyramid_gradient_defines.svh"

module masked_pyramid_gradient #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pmg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pmg_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [pmg_pkg::PIX_W-1:0]            i_pixel,
    input  logic                                 i_start_of_frame,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [pmg_pkg::GRAD_W-1:0]    o_grad_x,
    output logic signed [pmg_pkg::GRAD_W-1:0]    o_grad_y,
    output logic [pmg_pkg::MAG_W-1:0]            o_grad_mag_sq,
    output logic                                 o_grad_valid,
    output logic [pmg_pkg::PIX_W-1:0]            o_down_pixel,
    output logic                                 o_down_valid,
    output logic                                 o_frame_last
);
    import pmg_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (WW > CFG_W) ? WW : CFG_W;
    localparam int HCMP = (HW > CFG_W) ? HW : CFG_W;
    localparam int KW   = $clog2(2 * MAX_WIDTH + 1);
    localparam int PW   = $clog2(MAX_WIDTH / 2);

    logic [CFG_W-1:0] r_level_width;
    logic [CFG_W-1:0] r_level_height;
    logic             r_down_enable;

    logic [WCMP-1:0]  w_ext, w_sat;
    logic [HCMP-1:0]  h_ext, h_sat;
    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;

    logic [WW-1:0]    r_col, n_col, c0, col;
    logic [HW-1:0]    r_row, n_row, r0, row;
    t_pix             r_prev;

    logic             acc;
    logic             s1_free;
    t_flags           flags;
    logic [PSUM_W-1:0] psum;
    logic [PCNT_W-1:0] pcnt;
    t_pair            pair_wdata;
    t_pair            pair_q;
    logic             pair_wr;
    logic [PW-1:0]    pair_idx;

    logic [KW-1:0]    k_right, k_left, k_above;
    t_pix             win_right, win_left, win_above;
    t_win_ok          win_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_width  <= RST_LEVEL_WIDTH;
            r_level_height <= RST_LEVEL_HEIGHT;
            r_down_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEVEL_WIDTH:  r_level_width  <= i_cfg_data;
                REG_LEVEL_HEIGHT: r_level_height <= i_cfg_data;
                REG_DOWN_ENABLE:  r_down_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective geometry: saturated, width made even
    always_comb begin
        w_ext = WCMP'(r_level_width);
        h_ext = HCMP'(r_level_height);
        priority if (w_ext < WCMP'(MIN_WIDTH)) begin
            w_sat = WCMP'(MIN_WIDTH);
        end else if (w_ext > WCMP'(MAX_WIDTH)) begin
            w_sat = WCMP'(MAX_WIDTH);
        end else begin
            w_sat = w_ext;
        end
        priority if (h_ext < HCMP'(MIN_HEIGHT)) begin
            h_sat = HCMP'(MIN_HEIGHT);
        end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
            h_sat = HCMP'(MAX_HEIGHT);
        end else begin
            h_sat = h_ext;
        end
        eff_w = WW'(w_sat) & ~WW'(1);
        eff_h = HW'(h_sat);
    end

    // position of the incoming pixel and the counters after it
    always_comb begin
        c0  = i_start_of_frame ? '0 : r_col;
        r0  = i_start_of_frame ? '0 : r_row;
        col = c0;
        row = r0;
        if (c0 >= eff_w) begin
            col = '0;
            row = r0 + HW'(1);
        end
        if (row >= eff_h) begin
            row = '0;
        end
        n_col = col + WW'(1);
        n_row = row;
        if (n_col >= eff_w) begin
            n_col = '0;
            n_row = (row + HW'(1) >= eff_h) ? '0 : row + HW'(1);
        end
    end

    assign acc     = i_valid && s1_free;
    assign o_stall = !s1_free;

    assign flags.grad = row >= HW'(2);
    assign flags.down = col[0] && row[0] && r_down_enable;
    assign flags.last = (col == eff_w - WW'(1)) && (row == eff_h - HW'(1));

    assign psum = {1'b0, i_pixel} + {1'b0, r_prev};
    assign pcnt = {1'b0, i_pixel != '0} + {1'b0, r_prev != '0};

    assign pair_wdata.sum = psum;
    assign pair_wdata.cnt = pcnt;
    assign pair_wr        = acc && col[0] && !row[0];
    assign pair_idx       = PW'(col >> 1);

    assign k_right = KW'(eff_w) - KW'(1);
    assign k_left  = KW'(eff_w) + KW'(1);
    assign k_above = KW'(eff_w) << 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_prev <= '0;
        end else if (acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_prev <= i_pixel;
        end
    end

    pmg_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (acc),
        .i_pixel   (i_pixel),
        .i_k_right (k_right),
        .i_k_left  (k_left),
        .i_k_above (k_above),
        .o_right   (win_right),
        .o_left    (win_left),
        .o_above   (win_above),
        .o_ok      (win_ok)
    );

    pmg_pair #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pair (
        .i_clk  (i_clk),
        .i_wr   (pair_wr),
        .i_rd   (acc),
        .i_idx  (pair_idx),
        .i_data (pair_wdata),
        .o_q    (pair_q)
    );

    pmg_arith u_arith (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_below       (i_pixel),
        .i_psum        (psum),
        .i_pcnt        (pcnt),
        .i_flags       (flags),
        .i_right       (win_right),
        .i_left        (win_left),
        .i_above       (win_above),
        .i_ok          (win_ok),
        .i_pair        (pair_q),
        .i_stall       (i_stall),
        .o_s1_free     (s1_free),
        .o_valid       (o_valid),
        .o_grad_x      (o_grad_x),
        .o_grad_y      (o_grad_y),
        .o_grad_mag_sq (o_grad_mag_sq),
        .o_grad_valid  (o_grad_valid),
        .o_down_pixel  (o_down_pixel),
        .o_down_valid  (o_down_valid),
        .o_frame_last  (o_frame_last)
    );

    `PMG_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (o_valid && i_stall), "input stalled while output can move")
    `PMG_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule
